@@ src/closest_pair_chebyshev_gap_assert.svh @@
// Assertion macros shared by the checker of the closest pair block.
`ifndef CLOSEST_PAIR_CHEBYSHEV_GAP_ASSERT_SVH
`define CLOSEST_PAIR_CHEBYSHEV_GAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("closest pair check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("closest pair check failed");

`endif

@@ src/cpcg_pkg.sv @@
package cpcg_pkg;

    localparam int CPCG_COORD_BITS = 10;
    localparam int CPCG_IDX_BITS   = 6;
    localparam int CPCG_ERR_BITS   = 2;
    localparam int CPCG_MAX_POINTS = 64;

    localparam logic [CPCG_ERR_BITS-1:0] ERR_OK       = 2'd0;
    localparam logic [CPCG_ERR_BITS-1:0] ERR_EMPTY    = 2'd1;
    localparam logic [CPCG_ERR_BITS-1:0] ERR_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                       second_set;
        logic [CPCG_COORD_BITS-1:0] point_x;
        logic [CPCG_COORD_BITS-1:0] point_y;
        logic                       end_of_job;
    } t_item;

    typedef struct packed {
        logic [CPCG_COORD_BITS-1:0] hop_distance;
        logic [CPCG_IDX_BITS-1:0]   first_index;
        logic [CPCG_IDX_BITS-1:0]   second_index;
        logic [CPCG_ERR_BITS-1:0]   error_code;
    } t_result;

endpackage

@@ src/closest_pair_chebyshev_gap.sv @@
// Busy stays low while loading, and a new load item is taken every cycle.
// An end-of-job item with both sets filled starts the pair scan, which reads one pair per cycle
// from the two point memories, then passes through three pipeline stages before o_valid rises.
// An end-of-job item with an empty set raises o_valid on the next cycle. The result strobe
// lasts one cycle and cannot be stalled.
// Reset (synchronous, active low) empties both sets and clears the overflow flag.
module closest_pair_chebyshev_gap #(
    parameter int MAX_POINTS = cpcg_pkg::CPCG_MAX_POINTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  cpcg_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_valid,
    output cpcg_pkg::t_result o_result
);
    import cpcg_pkg::*;

    // Index and count widths follow the depth of the point memories.
    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PT_W   = 2 * CPCG_COORD_BITS;
    localparam int SQ_W   = 2 * CPCG_COORD_BITS;
    localparam int DIST_W = SQ_W + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Each memory word holds one point as {x, y}.
    logic [PT_W-1:0] r_first_mem  [MAX_POINTS];
    logic [PT_W-1:0] r_second_mem [MAX_POINTS];
    logic [PT_W-1:0] r_first_rd;
    logic [PT_W-1:0] r_second_rd;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_first_count;
    logic [CNT_W-1:0] r_second_count;
    logic             r_overflow;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_last_i;
    logic [IDX_W-1:0] r_last_j;

    // Scan pipeline: memory read, absolute gaps, squares.
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_last1;
    logic                       r_last2;
    logic                       r_last3;
    logic [IDX_W-1:0]           r_i1;
    logic [IDX_W-1:0]           r_j1;
    logic [IDX_W-1:0]           r_i2;
    logic [IDX_W-1:0]           r_j2;
    logic [IDX_W-1:0]           r_i3;
    logic [IDX_W-1:0]           r_j3;
    logic [CPCG_COORD_BITS-1:0] r_dx;
    logic [CPCG_COORD_BITS-1:0] r_dy;
    logic [SQ_W-1:0]            r_sq_x;
    logic [SQ_W-1:0]            r_sq_y;
    logic [CPCG_COORD_BITS-1:0] r_hop3;

    // Best pair found so far.
    logic                       r_have;
    logic [DIST_W-1:0]          r_best_d;
    logic [IDX_W-1:0]           r_best_i;
    logic [IDX_W-1:0]           r_best_j;
    logic [CPCG_COORD_BITS-1:0] r_best_hop;

    logic                       accept;
    logic                       first_full;
    logic                       second_full;
    logic                       wr_first;
    logic                       wr_second;
    logic [CNT_W-1:0]           n_first_count;
    logic [CNT_W-1:0]           n_second_count;
    logic                       n_overflow;
    logic [IDX_W-1:0]           n_last_i;
    logic [IDX_W-1:0]           n_last_j;
    logic                       end_empty;
    logic                       end_scan;
    logic                       issue;
    logic                       last_issue;
    logic                       finish;
    logic                       take;
    logic [DIST_W-1:0]          sum_sq;
    logic [PT_W-1:0]            pt_in;
    logic [CPCG_COORD_BITS-1:0] ax;
    logic [CPCG_COORD_BITS-1:0] ay;
    logic [CPCG_COORD_BITS-1:0] bx;
    logic [CPCG_COORD_BITS-1:0] by;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // A point sent to a full set is dropped and remembered as an overflow.
    assign first_full     = (r_first_count == CNT_W'(MAX_POINTS));
    assign second_full    = (r_second_count == CNT_W'(MAX_POINTS));
    assign wr_first       = accept && !i_item.second_set && !first_full;
    assign wr_second      = accept && i_item.second_set && !second_full;
    assign n_first_count  = r_first_count + CNT_W'(wr_first);
    assign n_second_count = r_second_count + CNT_W'(wr_second);
    assign n_overflow     = r_overflow
                          | (accept && (i_item.second_set ? second_full : first_full));
    assign n_last_i       = IDX_W'(n_first_count - CNT_W'(1));
    assign n_last_j       = IDX_W'(n_second_count - CNT_W'(1));
    assign pt_in          = {i_item.point_x, i_item.point_y};

    assign end_empty = accept && i_item.end_of_job
                     && ((n_first_count == '0) || (n_second_count == '0));
    assign end_scan  = accept && i_item.end_of_job && !end_empty;

    // One pair address goes out per cycle while scanning, second set innermost.
    assign issue      = (r_state == ST_SCAN);
    assign last_issue = issue && (r_i == r_last_i) && (r_j == r_last_j);

    assign ax = r_first_rd[PT_W-1:CPCG_COORD_BITS];
    assign ay = r_first_rd[CPCG_COORD_BITS-1:0];
    assign bx = r_second_rd[PT_W-1:CPCG_COORD_BITS];
    assign by = r_second_rd[CPCG_COORD_BITS-1:0];

    // Strict compare keeps the earliest pair in scan order among equal distances.
    assign sum_sq = DIST_W'(r_sq_x) + DIST_W'(r_sq_y);
    assign take   = r_v3 && (!r_have || (sum_sq < r_best_d));
    assign finish = (r_state == ST_DRAIN) && r_v3 && r_last3;

    // Point memories: one write port for loading, one registered read port for the scan.
    // The scan starts the cycle after the end-of-job write, so it sees that point.
    always_ff @(posedge i_clk) begin
        if (wr_first) begin
            r_first_mem[r_first_count[IDX_W-1:0]] <= pt_in;
        end
        r_first_rd <= r_first_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (wr_second) begin
            r_second_mem[r_second_count[IDX_W-1:0]] <= pt_in;
        end
        r_second_rd <= r_second_mem[r_j];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_overflow     <= 1'b0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_have         <= 1'b0;
            o_valid        <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (take) begin
                r_have <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_first_count  <= n_first_count;
                        r_second_count <= n_second_count;
                        r_overflow     <= n_overflow;
                    end
                    if (end_empty) begin
                        o_valid        <= 1'b1;
                        r_first_count  <= '0;
                        r_second_count <= '0;
                        r_overflow     <= 1'b0;
                    end
                    if (end_scan) begin
                        r_state <= ST_SCAN;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_have  <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (r_j == r_last_j) begin
                        r_j <= '0;
                        r_i <= r_i + IDX_W'(1);
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                    if (last_issue) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (finish) begin
                        o_valid        <= 1'b1;
                        r_state        <= ST_IDLE;
                        r_first_count  <= '0;
                        r_second_count <= '0;
                        r_overflow     <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Scan datapath and result payload.
    always_ff @(posedge i_clk) begin
        if (end_scan) begin
            r_last_i <= n_last_i;
            r_last_j <= n_last_j;
        end

        r_i1    <= r_i;
        r_j1    <= r_j;
        r_last1 <= last_issue;

        r_dx    <= (ax >= bx) ? (ax - bx) : (bx - ax);
        r_dy    <= (ay >= by) ? (ay - by) : (by - ay);
        r_i2    <= r_i1;
        r_j2    <= r_j1;
        r_last2 <= r_last1;

        r_sq_x  <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sq_y  <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_hop3  <= (r_dx > r_dy) ? r_dx : r_dy;
        r_i3    <= r_i2;
        r_j3    <= r_j2;
        r_last3 <= r_last2;

        if (take) begin
            r_best_d   <= sum_sq;
            r_best_i   <= r_i3;
            r_best_j   <= r_j3;
            r_best_hop <= r_hop3;
        end

        if (end_empty) begin
            o_result.hop_distance <= '0;
            o_result.first_index  <= '0;
            o_result.second_index <= '0;
            o_result.error_code   <= ERR_EMPTY;
        end else if (finish) begin
            // The last pair may itself be the winner, so look past the best registers.
            o_result.hop_distance <= take ? r_hop3 : r_best_hop;
            o_result.first_index  <= CPCG_IDX_BITS'(take ? r_i3 : r_best_i);
            o_result.second_index <= CPCG_IDX_BITS'(take ? r_j3 : r_best_j);
            o_result.error_code   <= r_overflow ? ERR_OVERFLOW : ERR_OK;
        end
    end

endmodule

@@ src/cpcg_checker.sv @@
`include "closest_pair_chebyshev_gap_assert.svh"

module cpcg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input cpcg_pkg::t_item   i_item,
    input logic              busy,
    input logic              o_valid,
    input cpcg_pkg::t_result o_result
);
    import cpcg_pkg::*;

    // A load item never starts a search or produces a result.
    `CPCG_ASSERT_NXT(a_load_quiet, i_clk, i_rst_n, start && !busy && !i_item.end_of_job, !busy && !o_valid)

    // The search always ends with a result.
    `CPCG_ASSERT_IMP(a_done_strobe, i_clk, i_rst_n, $fell(busy), o_valid)

    // An empty-set result carries zero payload.
    `CPCG_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && (o_result.error_code == ERR_EMPTY), (o_result.hop_distance == '0) && (o_result.first_index == '0) && (o_result.second_index == '0))

    // A result of a real search only follows a busy period.
    `CPCG_ASSERT_IMP(a_search_busy, i_clk, i_rst_n, o_valid && (o_result.error_code != ERR_EMPTY), $past(busy))

endmodule

bind closest_pair_chebyshev_gap cpcg_checker u_cpcg_checker (.*);

@@ tb/closest_pair_chebyshev_gap_tb.sv @@
`timescale 1ns / 100ps

module closest_pair_chebyshev_gap_tb;

    import cpcg_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int POINT_SLOTS   = CPCG_MAX_POINTS;
    localparam int RANDOM_POINTS = 1500;
    // The longest scan is a full 64 x 64 sweep plus three pipeline stages,
    // so a short settle time after the last answer is plenty.
    localparam int SETTLE_CYCLES = 20;

    typedef logic [CPCG_COORD_BITS-1:0] coord_t;

    // Scoreboard: keeps its own copy of both point sets, runs the pair search
    // whenever an end-of-job point is accepted, and matches the answers that
    // the block emits against the queue of predicted ones.
    class closest_pair_scoreboard;
        coord_t      first_x[POINT_SLOTS];
        coord_t      first_y[POINT_SLOTS];
        coord_t      second_x[POINT_SLOTS];
        coord_t      second_y[POINT_SLOTS];
        int unsigned first_count;
        int unsigned second_count;
        bit          overflow_seen;
        t_result     awaited_answers[$];
        int unsigned mismatches;

        function new();
            first_count   = 0;
            second_count  = 0;
            overflow_seen = 1'b0;
            mismatches    = 0;
        endfunction

        function int unsigned gap(coord_t a, coord_t b);
            return (a >= b) ? int'(a - b) : int'(b - a);
        endfunction

        // Brute-force scan in row-major order, first set outer. Only a
        // strictly smaller squared distance replaces the best pair, so the
        // earliest pair wins a tie.
        function t_result search_closest();
            t_result     answer;
            int unsigned best_d;
            int unsigned d;
            int unsigned dx;
            int unsigned dy;
            int          best_i;
            int          best_j;
            bit          found;
            answer = '0;
            if (first_count == 0 || second_count == 0) begin
                answer.error_code = ERR_EMPTY;
                return answer;
            end
            found  = 1'b0;
            best_d = 0;
            best_i = 0;
            best_j = 0;
            for (int i = 0; i < first_count; i++) begin
                for (int j = 0; j < second_count; j++) begin
                    dx = gap(first_x[i], second_x[j]);
                    dy = gap(first_y[i], second_y[j]);
                    d  = dx * dx + dy * dy;
                    if (!found || d < best_d) begin
                        found  = 1'b1;
                        best_d = d;
                        best_i = i;
                        best_j = j;
                    end
                end
            end
            dx = gap(first_x[best_i], second_x[best_j]);
            dy = gap(first_y[best_i], second_y[best_j]);
            answer.hop_distance = CPCG_COORD_BITS'((dx > dy) ? dx : dy);
            answer.first_index  = CPCG_IDX_BITS'(best_i);
            answer.second_index = CPCG_IDX_BITS'(best_j);
            answer.error_code   = overflow_seen ? ERR_OVERFLOW : ERR_OK;
            return answer;
        endfunction

        function void record_point(t_item item);
            if (item.second_set) begin
                if (second_count < POINT_SLOTS) begin
                    second_x[second_count] = item.point_x;
                    second_y[second_count] = item.point_y;
                    second_count++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end else begin
                if (first_count < POINT_SLOTS) begin
                    first_x[first_count] = item.point_x;
                    first_y[first_count] = item.point_y;
                    first_count++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            if (item.end_of_job) begin
                awaited_answers = {awaited_answers, search_closest()};
                first_count   = 0;
                second_count  = 0;
                overflow_seen = 1'b0;
            end
        endfunction

        function void compare_field(string field, logic [CPCG_COORD_BITS-1:0] want,
                                    logic [CPCG_COORD_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_answer(t_result got);
            t_result want;
            if (awaited_answers.size() == 0) begin
                $display("%0t: answer with none expected, got %p", $time, got);
                mismatches++;
                return;
            end
            want = awaited_answers.pop_front();
            compare_field("hop_distance", want.hop_distance, got.hop_distance);
            compare_field("first_index", CPCG_COORD_BITS'(want.first_index),
                          CPCG_COORD_BITS'(got.first_index));
            compare_field("second_index", CPCG_COORD_BITS'(want.second_index),
                          CPCG_COORD_BITS'(got.second_index));
            compare_field("error_code", CPCG_COORD_BITS'(want.error_code),
                          CPCG_COORD_BITS'(got.error_code));
        endfunction
    endclass

    // All block inputs start at known values: reset held, no command.
    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    closest_pair_scoreboard book = new();

    // Sender idles at random only while this is set; one stretch of jobs in
    // the random part clears it so that items go in back to back.
    bit          gaps_on;
    int unsigned random_items;
    int unsigned job_no;
    int unsigned large_jobs;

    closest_pair_chebyshev_gap dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // The strobe cannot be stalled, so every cycle with o_valid high is one
    // answer. Values are read as they stood before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            book.check_answer(o_result);
        end
    end

    // Sends one point. An item is taken at the edge where start is high and
    // busy is low; start stays high between back-to-back items so that it
    // never gets two assignments in one step.
    task automatic send_point(bit to_second, coord_t x, coord_t y, bit last);
        t_item item;
        item.second_set = to_second;
        item.point_x    = x;
        item.point_y    = y;
        item.end_of_job = last;
        while (gaps_on && $urandom_range(99, 0) < 33) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        book.record_point(item);
    endtask

    // Holds the sender off until every predicted answer has come back.
    task automatic wait_for_answers();
        start <= 1'b0;
        while (book.awaited_answers.size() != 0) @(posedge i_clk);
    endtask

    // Coordinates: a narrow job crowds points into a tiny box so that ties and
    // coincident points are common; otherwise the full range with extra
    // weight on both ends.
    function automatic coord_t pick_coord(bit narrow);
        if (narrow) begin
            return coord_t'($urandom_range(7, 0));
        end
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            default: return coord_t'($urandom_range((1 << CPCG_COORD_BITS) - 1, 0));
        endcase
    endfunction

    // One well-formed job: the given number of points per set in a shuffled
    // order, with end of job on the last one.
    task automatic run_job(int unsigned n_first, int unsigned n_second, bit narrow);
        bit          tags[$];
        bit          swap;
        int unsigned pick;
        int unsigned total;
        total = n_first + n_second;
        for (int i = 0; i < total; i++) begin
            tags = {tags, bit'(i >= n_first)};
        end
        for (int i = total - 1; i > 0; i--) begin
            pick       = $urandom_range(i, 0);
            swap       = tags[i];
            tags[i]    = tags[pick];
            tags[pick] = swap;
        end
        for (int i = 0; i < total; i++) begin
            send_point(tags[i], pick_coord(narrow), pick_coord(narrow), i == total - 1);
        end
        random_items += total;
    endtask

    // Loose points with a random set and an occasional end of job, so that
    // jobs of odd shapes and leftovers from unfinished ones also get through.
    task automatic run_noise(int unsigned count);
        for (int i = 0; i < count; i++) begin
            send_point($urandom_range(1, 0), pick_coord(1'b0), pick_coord(1'b0),
                       $urandom_range(9, 0) == 0);
        end
        random_items += count;
    endtask

    initial begin
        int unsigned kind;
        int unsigned n_full;
        int unsigned n_rest;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on = 1'b1;

        // Directed jobs. A lone end-of-job point leaves the other set empty,
        // in either direction, and must report the empty-set code.
        send_point(1'b0, 10'd0, 10'd0, 1'b1);
        send_point(1'b1, 10'd1023, 10'd1023, 1'b1);
        // Opposite corners: the largest possible distance on both axes.
        send_point(1'b0, 10'd0, 10'd0, 1'b0);
        send_point(1'b1, 10'd1023, 10'd1023, 1'b1);
        send_point(1'b1, 10'd1023, 10'd0, 1'b0);
        send_point(1'b0, 10'd0, 10'd1023, 1'b1);
        // Three second-set points at the same distance: the first one wins.
        send_point(1'b0, 10'd5, 10'd5, 1'b0);
        send_point(1'b1, 10'd6, 10'd5, 1'b0);
        send_point(1'b1, 10'd5, 10'd6, 1'b0);
        send_point(1'b1, 10'd4, 10'd5, 1'b1);
        // Euclidean and Chebyshev order disagree: (4,0) is nearer than (3,3)
        // but has the larger hop distance.
        send_point(1'b0, 10'd0, 10'd0, 1'b0);
        send_point(1'b1, 10'd3, 10'd3, 1'b0);
        send_point(1'b1, 10'd4, 10'd0, 1'b1);
        // Coincident points tie on the outer loop: index zero is kept.
        send_point(1'b0, 10'd100, 10'd100, 1'b0);
        send_point(1'b0, 10'd100, 10'd100, 1'b0);
        send_point(1'b1, 10'd100, 10'd100, 1'b1);
        // End of job on a first-set point that is itself the closest one.
        send_point(1'b1, 10'd512, 10'd511, 1'b0);
        send_point(1'b0, 10'd0, 10'd0, 1'b0);
        send_point(1'b0, 10'd512, 10'd512, 1'b1);
        // Mixed all-ones and all-zeros coordinates.
        send_point(1'b0, 10'd1023, 10'd0, 1'b0);
        send_point(1'b1, 10'd0, 10'd1023, 1'b0);
        send_point(1'b1, 10'd1023, 10'd1, 1'b1);
        wait_for_answers();

        // Random part. Mostly small well-formed jobs; some empty-set jobs,
        // overflowing jobs (with and without an empty partner set), noise,
        // and a few full 64 x 64 scans.
        random_items = 0;
        job_no       = 0;
        large_jobs   = 0;
        while (random_items < RANDOM_POINTS) begin
            gaps_on = !(job_no >= 30 && job_no < 60);
            if (job_no % 40 == 39) begin
                wait_for_answers();
            end
            kind = $urandom_range(99, 0);
            if (kind < 60) begin
                run_job($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(9, 0) < 3);
            end else if (kind < 70) begin
                if ($urandom_range(1, 0)) begin
                    run_job($urandom_range(6, 1), 0, 1'b0);
                end else begin
                    run_job(0, $urandom_range(6, 1), 1'b0);
                end
            end else if (kind < 78) begin
                run_job($urandom_range(24, 1), $urandom_range(24, 1), $urandom_range(1, 0));
            end else if (kind < 84) begin
                // One set gets more points than it can hold.
                n_full = $urandom_range(POINT_SLOTS + 6, POINT_SLOTS + 1);
                n_rest = $urandom_range(3, 0);
                if ($urandom_range(1, 0)) begin
                    run_job(n_full, n_rest, 1'b0);
                end else begin
                    run_job(n_rest, n_full, 1'b0);
                end
            end else if (kind < 94 || large_jobs >= 3) begin
                run_noise($urandom_range(10, 1));
            end else begin
                large_jobs++;
                run_job(POINT_SLOTS, POINT_SLOTS + $urandom_range(2, 0), 1'b0);
            end
            job_no++;
        end

        // Drain: let every predicted answer arrive and the scan go idle.
        start <= 1'b0;
        while (book.awaited_answers.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.awaited_answers.size() == 0) begin
            $display("closest_pair_chebyshev_gap: match");
        end else begin
            $display("closest_pair_chebyshev_gap: mismatch");
        end
        $finish;
    end

    // Watchdog: ends the run as a mismatch long after the slowest correct run would have finished.
    initial begin
        #9_600_000;
        $display("closest_pair_chebyshev_gap: mismatch");
        $finish;
    end

endmodule
